// File: rtl/mpsm_pkg.sv
// Shared types, codes and constants for the motor PWM setpoint and speed meter.
package mpsm_pkg;

    localparam int PULSE_BITS  = 32;
    localparam int SPEED_SHIFT = 7;
    // pulses * 10 needs four more bits than the counter
    localparam int PROD_BITS   = PULSE_BITS + 4;
    localparam int RAW_BITS    = PROD_BITS - SPEED_SHIFT;
    localparam int SAT_BITS    = (RAW_BITS > 17) ? RAW_BITS : 17;

    localparam int DUTY_BITS   = 16;
    localparam int TICK_BITS   = 8;
    localparam int CFG_BITS    = 16;
    localparam int IDX_BITS    = 2;

    localparam logic [DUTY_BITS-1:0] DUTY_STEP_RST  = 16'd500;
    localparam logic [DUTY_BITS-1:0] DUTY_TOP_RST   = 16'd7999;
    localparam logic [TICK_BITS-1:0] GATE_TICKS_RST = 8'd20;
    localparam logic [TICK_BITS-1:0] SCAN_TICKS_RST = 8'd5;
    localparam logic [DUTY_BITS-1:0] SPEED_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_PULSE = 2'd0,
        CMD_GATE  = 2'd1,
        CMD_SCAN  = 2'd2
    } cmd_code_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_DUTY_STEP  = 2'd0,
        REG_DUTY_TOP   = 2'd1,
        REG_GATE_TICKS = 2'd2,
        REG_SCAN_TICKS = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty_step;
        logic [DUTY_BITS-1:0] duty_top;
        logic [TICK_BITS-1:0] gate_ticks;
        logic [TICK_BITS-1:0] scan_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] command;
        logic       press_up;
        logic       press_down;
        logic       press_reverse;
        logic       press_stop;
    } item_t;

endpackage

// File: rtl/motor_pwm_setpoint_and_speed_meter.sv
// Top level of the motor PWM setpoint and encoder speed meter.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall   command, press_up/down/reverse/stop
//   out      source     out_valid / out_stall speed_tenths, compare_value,
//                                             reverse_out, stop_out, duty_level
//   cfg      sink       cfg_we                cfg_index, cfg_data
//
// One word per clock while the result side does not stall; an accepted word passes
// through the input register, then the update stage whose state registers form the result.
// The result word is a snapshot of the state registers, which change only as a word
// moves into the result register.
// A stalled result holds; the input register still takes one more word.
// Reset clears all counters and state and loads the register defaults.
module motor_pwm_setpoint_and_speed_meter
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     command,
    input  logic                           press_up,
    input  logic                           press_down,
    input  logic                           press_reverse,
    input  logic                           press_stop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mpsm_pkg::DUTY_BITS-1:0] speed_tenths,
    output logic [mpsm_pkg::DUTY_BITS-1:0] compare_value,
    output logic                           reverse_out,
    output logic                           stop_out,
    output logic [mpsm_pkg::DUTY_BITS-1:0] duty_level,
    input  logic                           cfg_we,
    input  logic [mpsm_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [mpsm_pkg::CFG_BITS-1:0]  cfg_data
);
    import mpsm_pkg::*;

    cfg_t  cfg;
    item_t item_in;
    item_t item_held;
    logic  item_valid;
    logic  advance;

    assign item_in.command       = command;
    assign item_in.press_up      = press_up;
    assign item_in.press_down    = press_down;
    assign item_in.press_reverse = press_reverse;
    assign item_in.press_stop    = press_stop;

    mpsm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpsm_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_out   (item_held)
    );

    mpsm_update u_upd
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .item_valid    (item_valid),
        .item          (item_held),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .speed_tenths  (speed_tenths),
        .compare_value (compare_value),
        .reverse_out   (reverse_out),
        .stop_out      (stop_out),
        .duty_level    (duty_level)
    );

endmodule

// File: rtl/mpsm_cfg_regs.sv
// Configuration register bank: duty step, duty top, gate and scan settings.
module mpsm_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mpsm_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [mpsm_pkg::CFG_BITS-1:0] cfg_data,
    output mpsm_pkg::cfg_t                cfg
);
    import mpsm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_step  <= DUTY_STEP_RST;
            cfg_reg.duty_top   <= DUTY_TOP_RST;
            cfg_reg.gate_ticks <= GATE_TICKS_RST;
            cfg_reg.scan_ticks <= SCAN_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_DUTY_STEP:  cfg_reg.duty_step  <= cfg_data[DUTY_BITS-1:0];
                REG_DUTY_TOP:   cfg_reg.duty_top   <= cfg_data[DUTY_BITS-1:0];
                REG_GATE_TICKS: cfg_reg.gate_ticks <= cfg_data[TICK_BITS-1:0];
                REG_SCAN_TICKS: cfg_reg.scan_ticks <= cfg_data[TICK_BITS-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/mpsm_in_stage.sv
// Input register: captures one command word and holds it until the update stage takes it.
module mpsm_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  mpsm_pkg::item_t item_in,
    input  logic            advance,
    output logic            item_valid,
    output mpsm_pkg::item_t item_out
);
    import mpsm_pkg::*;

    logic  valid_reg;
    logic  load;
    item_t item_reg;

    // take a new word when empty or when the held one moves on
    assign load     = !valid_reg || advance;
    assign in_stall = !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

// File: rtl/mpsm_update.sv
// Update stage: counters, speed latch, duty buttons and the registered result word.
module mpsm_update
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  mpsm_pkg::cfg_t                 cfg,
    input  logic                           item_valid,
    input  mpsm_pkg::item_t                item,
    output logic                           advance,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mpsm_pkg::DUTY_BITS-1:0] speed_tenths,
    output logic [mpsm_pkg::DUTY_BITS-1:0] compare_value,
    output logic                           reverse_out,
    output logic                           stop_out,
    output logic [mpsm_pkg::DUTY_BITS-1:0] duty_level
);
    import mpsm_pkg::*;

    logic                  out_valid_reg;
    logic [PULSE_BITS-1:0] pulse_reg,   pulse_next;
    logic [TICK_BITS-1:0]  gate_reg,    gate_next;
    logic [TICK_BITS-1:0]  scan_reg,    scan_next;
    logic [DUTY_BITS-1:0]  duty_reg,    duty_next;
    logic                  rev_reg,     rev_next;
    logic                  stop_reg,    stop_next;
    logic [DUTY_BITS-1:0]  speed_reg,   speed_next;
    logic [DUTY_BITS-1:0]  compare_reg, compare_next;

    logic [TICK_BITS-1:0]  gate_inc;
    logic [TICK_BITS-1:0]  scan_inc;
    logic [PROD_BITS-1:0]  pulse_wide;
    logic [PROD_BITS-1:0]  prod;
    logic [SAT_BITS-1:0]   speed_wide;
    logic [DUTY_BITS:0]    duty_sum;

    // result register free, or its word is being taken
    assign advance = item_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        gate_inc   = gate_reg + 1'b1;
        scan_inc   = scan_reg + 1'b1;
        pulse_wide = PROD_BITS'(pulse_reg);
        // times ten as shift and add
        prod       = (pulse_wide << 3) + (pulse_wide << 1);
        speed_wide = SAT_BITS'(prod[PROD_BITS-1:SPEED_SHIFT]);
        duty_sum   = {1'b0, duty_reg} + {1'b0, cfg.duty_step};

        pulse_next   = pulse_reg;
        gate_next    = gate_reg;
        scan_next    = scan_reg;
        duty_next    = duty_reg;
        rev_next     = rev_reg;
        stop_next    = stop_reg;
        speed_next   = speed_reg;
        compare_next = compare_reg;

        case (cmd_code_t'(item.command))
            CMD_PULSE:
            begin
                // saturate at the top
                if (pulse_reg != '1)
                begin
                    pulse_next = pulse_reg + 1'b1;
                end
            end
            CMD_GATE:
            begin
                if (gate_inc >= cfg.gate_ticks)
                begin
                    gate_next  = '0;
                    pulse_next = '0;
                    if (speed_wide > SAT_BITS'(SPEED_MAX))
                    begin
                        speed_next = SPEED_MAX;
                    end
                    else
                    begin
                        speed_next = speed_wide[DUTY_BITS-1:0];
                    end
                end
                else
                begin
                    gate_next = gate_inc;
                end
            end
            CMD_SCAN:
            begin
                if (scan_inc >= cfg.scan_ticks)
                begin
                    scan_next = '0;
                    // one press acted on, up first
                    if (item.press_up)
                    begin
                        if (duty_sum >= {1'b0, cfg.duty_top})
                        begin
                            duty_next = cfg.duty_top;
                        end
                        else
                        begin
                            duty_next = duty_sum[DUTY_BITS-1:0];
                        end
                    end
                    else if (item.press_down)
                    begin
                        if (duty_reg >= cfg.duty_step)
                        begin
                            duty_next = duty_reg - cfg.duty_step;
                        end
                        else
                        begin
                            duty_next = '0;
                        end
                    end
                    else if (item.press_reverse)
                    begin
                        rev_next = !rev_reg;
                    end
                    else if (item.press_stop)
                    begin
                        stop_next = !stop_reg;
                    end

                    // mirror against top; clamp to zero if top was lowered below duty
                    if (!rev_next)
                    begin
                        compare_next = duty_next;
                    end
                    else if (duty_next <= cfg.duty_top)
                    begin
                        compare_next = cfg.duty_top - duty_next;
                    end
                    else
                    begin
                        compare_next = '0;
                    end
                end
                else
                begin
                    scan_next = scan_inc;
                end
            end
            default:
            begin
                pulse_next = pulse_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pulse_reg     <= '0;
            gate_reg      <= '0;
            scan_reg      <= '0;
            duty_reg      <= '0;
            rev_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            speed_reg     <= '0;
            compare_reg   <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pulse_reg     <= pulse_next;
                gate_reg      <= gate_next;
                scan_reg      <= scan_next;
                duty_reg      <= duty_next;
                rev_reg       <= rev_next;
                stop_reg      <= stop_next;
                speed_reg     <= speed_next;
                compare_reg   <= compare_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign speed_tenths  = speed_reg;
    assign compare_value = compare_reg;
    assign reverse_out   = rev_reg;
    assign stop_out      = stop_reg;
    assign duty_level    = duty_reg;

endmodule

// File: rtl/mpsm_checker.sv
// Port-level checks for the motor PWM setpoint and speed meter, bound to the top level.
module mpsm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] speed_tenths,
    input logic [15:0] compare_value,
    input logic        reverse_out,
    input logic        stop_out,
    input logic [15:0] duty_level
);

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(speed_tenths) && $stable(compare_value)
            && $stable(duty_level)))
        else $error("stalled result word changed");

    // forward direction drives the duty straight to the timer
    a_forward_compare: assert property (@(posedge clk) disable iff (!rst_n)
        !reverse_out |-> (compare_value == duty_level))
        else $error("forward compare value differs from duty");

    // a scan action handles one press only
    a_one_press: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(reverse_out) |-> ($stable(stop_out) && $stable(duty_level)))
        else $error("direction toggle changed another setting");

endmodule

bind motor_pwm_setpoint_and_speed_meter mpsm_checker u_mpsm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .speed_tenths  (speed_tenths),
    .compare_value (compare_value),
    .reverse_out   (reverse_out),
    .stop_out      (stop_out),
    .duty_level    (duty_level)
);

// File: sim/motor_pwm_setpoint_and_speed_meter_tb.sv
// Self-checking testbench for the motor PWM setpoint and encoder speed meter.
module motor_pwm_setpoint_and_speed_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpsm_pkg::*;

    localparam logic [1:0] CMD_RESERVED  = 2'd3;
    // press vector order: {up, down, reverse, stop}
    localparam logic [3:0] PRESS_NONE    = 4'b0000;
    localparam logic [3:0] PRESS_UP      = 4'b1000;
    localparam logic [3:0] PRESS_DOWN    = 4'b0100;
    localparam logic [3:0] PRESS_REVERSE = 4'b0010;
    localparam logic [3:0] PRESS_STOP    = 4'b0001;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [DUTY_BITS-1:0] speed;
        logic [DUTY_BITS-1:0] compare;
        logic                 rev;
        logic                 stop;
        logic [DUTY_BITS-1:0] duty;
    } reading_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           command;
    logic                 press_up;
    logic                 press_down;
    logic                 press_reverse;
    logic                 press_stop;
    logic                 out_valid;
    logic                 out_stall;
    logic [DUTY_BITS-1:0] speed_tenths;
    logic [DUTY_BITS-1:0] compare_value;
    logic                 reverse_out;
    logic                 stop_out;
    logic [DUTY_BITS-1:0] duty_level;
    logic                 cfg_we;
    logic [IDX_BITS-1:0]  cfg_index;
    logic [CFG_BITS-1:0]  cfg_data;

    // local copy of the registers and the drive state
    logic [DUTY_BITS-1:0]  step_reg = DUTY_STEP_RST;
    logic [DUTY_BITS-1:0]  top_reg = DUTY_TOP_RST;
    logic [TICK_BITS-1:0]  gate_reg = GATE_TICKS_RST;
    logic [TICK_BITS-1:0]  scan_reg = SCAN_TICKS_RST;
    logic [PULSE_BITS-1:0] pulses = '0;
    logic [TICK_BITS-1:0]  gate_cnt = '0;
    logic [TICK_BITS-1:0]  scan_cnt = '0;
    logic [DUTY_BITS-1:0]  duty = '0;
    logic                  reversed = 1'b0;
    logic                  stopped = 1'b0;
    logic [DUTY_BITS-1:0]  speed = '0;
    logic [DUTY_BITS-1:0]  compare = '0;

    reading_t readings_due[$];
    int       fail_count = 0;
    int       cycle_count = 0;
    bit       steady_flow = 1'b0;
    bit       hold_out_req = 1'b0;

    motor_pwm_setpoint_and_speed_meter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .press_up      (press_up),
        .press_down    (press_down),
        .press_reverse (press_reverse),
        .press_stop    (press_stop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .speed_tenths  (speed_tenths),
        .compare_value (compare_value),
        .reverse_out   (reverse_out),
        .stop_out      (stop_out),
        .duty_level    (duty_level),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Apply one accepted word to the drive state and queue the reading it yields.
    task automatic advance_drive_state(input logic [1:0] cmd, input logic [3:0] pr);
        logic [PROD_BITS-1:0] prod;
        logic [PROD_BITS-1:0] raw;
        logic [DUTY_BITS:0]   sum;
        reading_t             r;
        case (cmd)
            CMD_PULSE:
                if (pulses != '1)
                    pulses = pulses + 1'b1;
            CMD_GATE:
            begin
                gate_cnt = gate_cnt + 1'b1;
                if (gate_cnt >= gate_reg)
                begin
                    gate_cnt = '0;
                    prod = PROD_BITS'(pulses);
                    prod = prod * 10;
                    raw = prod >> SPEED_SHIFT;
                    speed = (raw > SPEED_MAX) ? SPEED_MAX : raw[DUTY_BITS-1:0];
                    pulses = '0;
                end
            end
            CMD_SCAN:
            begin
                scan_cnt = scan_cnt + 1'b1;
                if (scan_cnt >= scan_reg)
                begin
                    scan_cnt = '0;
                    if ((pr & PRESS_UP) != 0)
                    begin
                        sum = duty + step_reg;
                        duty = (sum >= top_reg) ? top_reg : sum[DUTY_BITS-1:0];
                    end
                    else if ((pr & PRESS_DOWN) != 0)
                        duty = (duty >= step_reg) ? duty - step_reg : '0;
                    else if ((pr & PRESS_REVERSE) != 0)
                        reversed = ~reversed;
                    else if ((pr & PRESS_STOP) != 0)
                        stopped = ~stopped;
                    if (!reversed)
                        compare = duty;
                    else
                        compare = (duty <= top_reg) ? top_reg - duty : '0;
                end
            end
            default:
                ;
        endcase
        r.speed = speed;
        r.compare = compare;
        r.rev = reversed;
        r.stop = stopped;
        r.duty = duty;
        readings_due.push_back(r);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DUTY_STEP:  step_reg = cfg_data;
                    REG_DUTY_TOP:   top_reg = cfg_data;
                    REG_GATE_TICKS: gate_reg = cfg_data[TICK_BITS-1:0];
                    REG_SCAN_TICKS: scan_reg = cfg_data[TICK_BITS-1:0];
                    default:        ;
                endcase
            end
            if (in_valid && !in_stall)
                advance_drive_state(command, {press_up, press_down, press_reverse, press_stop});
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (readings_due.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                want = readings_due.pop_front();
                check_field("speed_tenths", want.speed, speed_tenths);
                check_field("compare_value", want.compare, compare_value);
                check_field("reverse_out", want.rev, reverse_out);
                check_field("stop_out", want.stop, stop_out);
                check_field("duty_level", want.duty, duty_level);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, or one long hold-off on request.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            if (hold_out_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_out_req = 1'b0;
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            repeat (steady_flow ? 1 : $urandom_range(1, 8)) @(posedge clk);
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [3:0] pr);
        int gap;
        command <= cmd;
        {press_up, press_down, press_reverse, press_stop} <= pr;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every expected reading is back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (readings_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_setting(input logic [DUTY_BITS-1:0] step, input logic [DUTY_BITS-1:0] top,
                                input logic [TICK_BITS-1:0] gate, input logic [TICK_BITS-1:0] scan);
        logic [7:0] junk;
        cfg_we <= 1'b1;
        cfg_index <= REG_DUTY_STEP;
        cfg_data <= step;
        @(posedge clk);
        cfg_index <= REG_DUTY_TOP;
        cfg_data <= top;
        @(posedge clk);
        // upper bits of the tick registers must be dropped
        junk = 8'($urandom);
        cfg_index <= REG_GATE_TICKS;
        cfg_data <= {junk, gate};
        @(posedge clk);
        junk = 8'($urandom);
        cfg_index <= REG_SCAN_TICKS;
        cfg_data <= {junk, scan};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [3:0] pick_presses();
        logic [3:0] lo;
        lo = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 4))
            1:       return PRESS_UP | lo;
            2:       return PRESS_DOWN | (lo & (PRESS_REVERSE | PRESS_STOP));
            3:       return PRESS_REVERSE | (lo & PRESS_STOP);
            4:       return PRESS_STOP;
            default: return PRESS_NONE;
        endcase
    endfunction

    task automatic send_mix(input int count, input int pulse_pct, input int gate_pct);
        int         r;
        logic [1:0] cmd;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                cmd = CMD_RESERVED;
            else if (r < pulse_pct)
                cmd = CMD_PULSE;
            else if (r < pulse_pct + gate_pct)
                cmd = CMD_GATE;
            else
                cmd = CMD_SCAN;
            send_word(cmd, (cmd == CMD_SCAN) ? pick_presses() : 4'($urandom_range(0, 15)));
        end
    endtask

    task automatic test_power_on();
        send_word(CMD_PULSE, PRESS_NONE);
        send_word(CMD_PULSE, PRESS_UP);
        repeat (5) send_word(CMD_SCAN, PRESS_UP);
        send_word(CMD_RESERVED, PRESS_UP | PRESS_DOWN | PRESS_REVERSE | PRESS_STOP);
        wait_drained();
    endtask

    task automatic test_press_corners();
        load_setting(16'hFFFF, 16'hFFFF, 8'd1, 8'd1);
        send_word(CMD_SCAN, PRESS_UP);
        send_word(CMD_SCAN, PRESS_UP);
        send_word(CMD_SCAN, PRESS_UP | PRESS_DOWN);
        send_word(CMD_SCAN, PRESS_DOWN);
        send_word(CMD_SCAN, PRESS_DOWN);
        wait_drained();
        load_setting(16'd1000, 16'd3000, 8'd1, 8'd1);
        repeat (4) send_word(CMD_SCAN, PRESS_UP);
        send_word(CMD_SCAN, PRESS_REVERSE | PRESS_STOP);
        send_word(CMD_SCAN, PRESS_STOP);
        send_word(CMD_SCAN, PRESS_NONE);
        wait_drained();
        // lower the top under a reversed duty: compare must floor at zero
        load_setting(16'd1000, 16'd1000, 8'd0, 8'd0);
        send_word(CMD_SCAN, PRESS_NONE);
        send_word(CMD_SCAN, PRESS_UP);
        send_word(CMD_SCAN, PRESS_DOWN | PRESS_REVERSE | PRESS_STOP);
        send_word(CMD_SCAN, PRESS_REVERSE);
        repeat (3) send_word(CMD_PULSE, PRESS_UP | PRESS_STOP);
        send_word(CMD_GATE, PRESS_DOWN | PRESS_REVERSE);
        send_word(CMD_RESERVED, PRESS_NONE);
        wait_drained();
    endtask

    task automatic test_setting_extremes();
        load_setting(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_mix(280, 10, 45);
        wait_drained();
        load_setting(16'd1, 16'd1, 8'd1, 8'd1);
        send_mix(40, 40, 30);
        wait_drained();
        load_setting(16'd1, 16'hFFFF, 8'd2, 8'd1);
        send_mix(40, 60, 20);
        wait_drained();
    endtask

    task automatic test_random_phases();
        logic [DUTY_BITS-1:0] step;
        logic [DUTY_BITS-1:0] top;
        logic [TICK_BITS-1:0] gate;
        logic [TICK_BITS-1:0] scan;
        repeat (9)
        begin
            step = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                               : 16'($urandom_range(1, 3000));
            top = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                              : 16'($urandom_range(1, 12000));
            gate = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 40))
                                               : 8'($urandom_range(1, 8));
            scan = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 20))
                                               : 8'($urandom_range(1, 5));
            load_setting(step, top, gate, scan);
            send_mix(110, $urandom_range(20, 70), $urandom_range(5, 20));
            wait_drained();
        end
    endtask

    task automatic test_output_hold();
        hold_out_req = 1'b1;
        send_mix(40, 40, 20);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        steady_flow = 1'b1;
        send_mix(120, 40, 20);
        wait_drained();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_PULSE;
        press_up = 1'b0;
        press_down = 1'b0;
        press_reverse = 1'b0;
        press_stop = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DUTY_STEP;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on();
        test_press_corners();
        test_setting_extremes();
        test_random_phases();
        test_output_hold();
        test_back_to_back();

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
